[hw/rtl/pli_pkg.sv]
// pli_pkg: shared widths, codes, word types and controller/datapath links
// for the piecewise linear interpolator; no dependencies
`timescale 1ns / 1ps

package pli_pkg;

	localparam int DATA_WIDTH   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int MAX_POINTS   = 64;
	localparam int COUNT_WIDTH  = 7;
	localparam int INDEX_WIDTH  = 6;
	localparam int STATUS_WIDTH = 2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = COUNT_WIDTH'(2);

	// function codes of an input word
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_EVAL  = 1'b1;

	// result status codes
	localparam logic [STATUS_WIDTH-1:0] STATUS_OK         = STATUS_WIDTH'(0);
	localparam logic [STATUS_WIDTH-1:0] STATUS_OUTSIDE    = STATUS_WIDTH'(1);
	localparam logic [STATUS_WIDTH-1:0] STATUS_ZERO_WIDTH = STATUS_WIDTH'(2);

	typedef struct packed {
		logic                          func;
		logic [INDEX_WIDTH-1:0]        entry_index;
		logic signed [DATA_WIDTH-1:0]  point_x;
		logic signed [DATA_WIDTH-1:0]  point_y;
	} pli_in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  interp_value;
		logic signed [DATA_WIDTH-1:0]  interp_slope;
		logic [INDEX_WIDTH-1:0]        segment_index;
		logic [STATUS_WIDTH-1:0]       status;
	} pli_out_t;

	// table read address select
	typedef enum logic [2:0] {
		RD_FIRST    = 3'd0,
		RD_LAST     = 3'd1,
		RD_MID      = 3'd2,
		RD_SEG      = 3'd3,
		RD_SEG_NEXT = 3'd4
	} pli_rd_sel_t;

	typedef struct packed {
		logic        write_entry;
		logic        load_query;
		pli_rd_sel_t rd_sel;
		logic        cap_first;
		logic        cap_last;
		logic        srch_step;
		logic        cap_seg;
		logic        cap_lo;
		logic        cap_diff;
		logic        mul;
		logic        div_start;
		logic        div_slope;
		logic        cap_value;
		logic        cap_slope;
		logic        res_outside;
		logic        res_zero;
		logic        out_load;
	} pli_cmd_t;

	typedef struct packed {
		logic srch_done;
		logic seg_outside;
		logic zero_width;
		logic slope_ovf;
		logic div_done;
	} pli_sts_t;

endpackage

[hw/rtl/pli_div.sv]
// pli_div: unsigned restoring divider, two quotient bits a cycle
// depends on pli_pkg; dividend upper half must be below the divisor
`timescale 1ns / 1ps

module pli_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [2*pli_pkg::DATA_WIDTH-1:0]    dividend,
	input  logic [pli_pkg::DATA_WIDTH-1:0]      divisor,
	output logic                                done,
	output logic [pli_pkg::DATA_WIDTH-1:0]      quotient
);

	localparam int DW    = pli_pkg::DATA_WIDTH;
	localparam int STEPS = DW / 2;
	localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [DW-1:0] rem_n;
	logic [DW-1:0] quo_n;

	// two shift-subtract steps
	always_comb begin
		logic [DW:0]   t;
		logic [DW-1:0] r;
		logic [DW-1:0] qv;
		r  = rem_q;
		qv = quo_q;
		for (int i = 0; i < 2; i++) begin
			t  = {r, qv[DW-1]};
			qv = {qv[DW-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				r     = DW'(t - {1'b0, dvs_q});
				qv[0] = 1'b1;
			end else begin
				r = t[DW-1:0];
			end
		end
		rem_n = r;
		quo_n = qv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= CW'(cnt_q + 1'b1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*DW-1:DW];
			quo_q <= dividend[DW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[hw/rtl/pli_datapath.sv]
// pli_datapath: breakpoint memories, search registers, multiplier and result
// word; depends on pli_pkg and pli_div, driven by pli_ctrl commands
`timescale 1ns / 1ps

module pli_datapath #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pli_pkg::COUNT_WIDTH-1:0]    cfg_data,
	input  pli_pkg::pli_in_t                   in_data,
	input  pli_pkg::pli_cmd_t                  cmd,
	output pli_pkg::pli_sts_t                  sts,
	output pli_pkg::pli_out_t                  out_data
);

	localparam int DW   = pli_pkg::DATA_WIDTH;
	localparam int FB   = pli_pkg::FRAC_BITS;
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW = $clog2(MAX_POINTS + 2);

	localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

	function automatic logic [DW-1:0] mag(input logic [DW:0] v);
		return v[DW] ? DW'(~v + 1'b1) : v[DW-1:0];
	endfunction

	function automatic logic signed [DW+1:0] apply_sign(input logic [DW-1:0] m,
		input logic neg);
		logic signed [DW+1:0] e;
		e = signed'({2'b00, m});
		return neg ? -e : e;
	endfunction

	function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] v);
		logic [2:0] top;
		top = v[DW+1:DW-1];
		if (top == 3'b000 || top == 3'b111)
			return v[DW-1:0];
		else if (v[DW+1])
			return SAT_MIN;
		else
			return SAT_MAX;
	endfunction

	logic [pli_pkg::COUNT_WIDTH-1:0]  point_count_q;
	logic signed [DW-1:0]             mem_x [MAX_POINTS];
	logic signed [DW-1:0]             mem_y [MAX_POINTS];
	logic signed [DW-1:0]             rd_x_q;
	logic signed [DW-1:0]             rd_y_q;
	logic signed [DW-1:0]             query_q;
	logic [CNTW-1:0]                  n_q;
	logic signed [DW-1:0]             x0_q;
	logic                             ascnd_q;
	logic                             hit_first_q;
	logic                             hit_last_q;
	logic [CNTW-1:0]                  lo_q;
	logic [CNTW-1:0]                  hi_q;
	logic [AW-1:0]                    seg_q;
	logic signed [DW-1:0]             xj_q;
	logic signed [DW-1:0]             yj_q;
	logic [DW-1:0]                    den_q;
	logic [DW-1:0]                    num_q;
	logic [DW-1:0]                    dym_q;
	logic                             sign_val_q;
	logic                             sign_slope_q;
	logic [2*DW-1:0]                  prod_q;
	logic signed [DW-1:0]             value_q;
	logic signed [DW-1:0]             slope_q;
	logic [pli_pkg::STATUS_WIDTH-1:0] status_q;
	pli_pkg::pli_out_t                out_q;

	logic [CNTW-1:0]  n_clamp;
	logic [CNTW:0]    mid_sum;
	logic [CNTW-1:0]  mid_p1;
	logic [AW-1:0]    seg_sel;
	logic [AW-1:0]    rd_addr;
	logic             mem_we;
	logic [DW:0]      dx_w;
	logic [DW:0]      dy_w;
	logic [DW:0]      diff_w;
	logic [2*DW-1:0]  slope_dividend;
	logic [2*DW-1:0]  div_dividend;
	logic             div_done;
	logic [DW-1:0]    div_quo;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= pli_pkg::COUNT_RESET;
		end else if (cfg_we) begin
			point_count_q <= cfg_data;
		end
	end

	// count below two acts as two, above the depth as the depth
	always_comb begin
		if (point_count_q < pli_pkg::COUNT_WIDTH'(2))
			n_clamp = CNTW'(2);
		else if (int'(point_count_q) > MAX_POINTS)
			n_clamp = CNTW'(MAX_POINTS);
		else
			n_clamp = CNTW'(point_count_q);
	end

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_p1  = mid_sum[CNTW:1];

	always_comb begin
		if (hit_first_q)
			seg_sel = '0;
		else if (hit_last_q)
			seg_sel = AW'(n_q - CNTW'(2));
		else
			seg_sel = AW'(lo_q - 1'b1);
	end

	always_comb begin
		unique case (cmd.rd_sel)
			pli_pkg::RD_FIRST:    rd_addr = '0;
			pli_pkg::RD_LAST:     rd_addr = AW'(n_q - 1'b1);
			pli_pkg::RD_MID:      rd_addr = AW'(mid_p1 - 1'b1);
			pli_pkg::RD_SEG:      rd_addr = seg_sel;
			pli_pkg::RD_SEG_NEXT: rd_addr = AW'(seg_q + 1'b1);
			default:              rd_addr = '0;
		endcase
	end

	// breakpoint memories, writes ignored beyond the depth
	assign mem_we = cmd.write_entry && (int'(in_data.entry_index) < MAX_POINTS);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_x[AW'(in_data.entry_index)] <= in_data.point_x;
			mem_y[AW'(in_data.entry_index)] <= in_data.point_y;
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	assign dx_w   = {rd_x_q[DW-1], rd_x_q} - {xj_q[DW-1], xj_q};
	assign dy_w   = {rd_y_q[DW-1], rd_y_q} - {yj_q[DW-1], yj_q};
	assign diff_w = {query_q[DW-1], query_q} - {xj_q[DW-1], xj_q};

	assign slope_dividend = {{DW{1'b0}}, dym_q} << FB;
	assign div_dividend   = cmd.div_slope ? slope_dividend : prod_q;

	pli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			query_q <= in_data.point_x;
			n_q     <= n_clamp;
		end
		if (cmd.cap_first) begin
			x0_q        <= rd_x_q;
			hit_first_q <= (query_q == rd_x_q);
		end
		if (cmd.cap_last) begin
			ascnd_q    <= (rd_x_q >= x0_q);
			hit_last_q <= (query_q == rd_x_q);
			lo_q       <= '0;
			hi_q       <= CNTW'(n_q + 1'b1);
		end
		if (cmd.srch_step) begin
			if ((query_q >= rd_x_q) == ascnd_q)
				lo_q <= mid_p1;
			else
				hi_q <= mid_p1;
		end
		if (cmd.cap_seg)
			seg_q <= seg_sel;
		if (cmd.cap_lo) begin
			xj_q <= rd_x_q;
			yj_q <= rd_y_q;
		end
		if (cmd.cap_diff) begin
			den_q        <= mag(dx_w);
			dym_q        <= mag(dy_w);
			num_q        <= mag(diff_w);
			sign_val_q   <= diff_w[DW] ^ dy_w[DW];
			sign_slope_q <= dx_w[DW] ^ dy_w[DW];
		end
		if (cmd.mul)
			prod_q <= num_q * dym_q;
		if (cmd.res_outside) begin
			value_q  <= '0;
			slope_q  <= '0;
			status_q <= pli_pkg::STATUS_OUTSIDE;
		end
		if (cmd.res_zero) begin
			value_q  <= '0;
			slope_q  <= '0;
			status_q <= pli_pkg::STATUS_ZERO_WIDTH;
		end
		if (cmd.cap_value) begin
			value_q  <= sat(signed'({{2{yj_q[DW-1]}}, yj_q}) +
				apply_sign(div_quo, sign_val_q));
			status_q <= pli_pkg::STATUS_OK;
		end
		if (cmd.cap_slope) begin
			if (sts.slope_ovf)
				slope_q <= sign_slope_q ? SAT_MIN : SAT_MAX;
			else
				slope_q <= sat(apply_sign(div_quo, sign_slope_q));
		end
		if (cmd.out_load) begin
			out_q.interp_value  <= value_q;
			out_q.interp_slope  <= slope_q;
			out_q.segment_index <= (status_q == pli_pkg::STATUS_OUTSIDE) ? '0 :
				pli_pkg::INDEX_WIDTH'(seg_q);
			out_q.status        <= status_q;
		end
	end

	assign sts.srch_done   = (hi_q == CNTW'(lo_q + 1'b1));
	assign sts.seg_outside = !hit_first_q && !hit_last_q && (lo_q == '0 || lo_q >= n_q);
	assign sts.zero_width  = (den_q == '0);
	assign sts.slope_ovf   = ((dym_q >> FB) >= den_q);
	assign sts.div_done    = div_done;

	assign out_data = out_q;

endmodule

[hw/rtl/pli_ctrl.sv]
// pli_ctrl: sequencing state machine for table writes, segment search and
// the divide steps; depends on pli_pkg, drives pli_datapath
`timescale 1ns / 1ps

module pli_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_func,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  pli_pkg::pli_sts_t   sts,
	output pli_pkg::pli_cmd_t   cmd
);

	typedef enum logic [14:0] {
		S_IDLE     = 15'b000000000000001,
		S_RD_FIRST = 15'b000000000000010,
		S_RD_LAST  = 15'b000000000000100,
		S_SRCH_INI = 15'b000000000001000,
		S_SRCH_RD  = 15'b000000000010000,
		S_SRCH_CMP = 15'b000000000100000,
		S_SEG_LO   = 15'b000000001000000,
		S_SEG_HI   = 15'b000000010000000,
		S_SEG_CAP  = 15'b000000100000000,
		S_MUL      = 15'b000001000000000,
		S_VAL_GO   = 15'b000010000000000,
		S_VAL_WAIT = 15'b000100000000000,
		S_SL_GO    = 15'b001000000000000,
		S_SL_WAIT  = 15'b010000000000000,
		S_OUT      = 15'b100000000000000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = pli_pkg::RD_FIRST;
		state_n    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_func == pli_pkg::FUNC_EVAL) begin
						cmd.load_query = 1'b1;
						state_n        = S_RD_FIRST;
					end else begin
						cmd.write_entry = 1'b1;
					end
				end
			end
			S_RD_FIRST: begin
				cmd.rd_sel = pli_pkg::RD_FIRST;
				state_n    = S_RD_LAST;
			end
			S_RD_LAST: begin
				cmd.rd_sel    = pli_pkg::RD_LAST;
				cmd.cap_first = 1'b1;
				state_n       = S_SRCH_INI;
			end
			S_SRCH_INI: begin
				cmd.cap_last = 1'b1;
				state_n      = S_SRCH_RD;
			end
			S_SRCH_RD: begin
				cmd.rd_sel = pli_pkg::RD_MID;
				state_n    = sts.srch_done ? S_SEG_LO : S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				cmd.srch_step = 1'b1;
				state_n       = S_SRCH_RD;
			end
			S_SEG_LO: begin
				cmd.rd_sel  = pli_pkg::RD_SEG;
				cmd.cap_seg = 1'b1;
				if (sts.seg_outside) begin
					cmd.res_outside = 1'b1;
					state_n         = S_OUT;
				end else begin
					state_n = S_SEG_HI;
				end
			end
			S_SEG_HI: begin
				cmd.rd_sel = pli_pkg::RD_SEG_NEXT;
				cmd.cap_lo = 1'b1;
				state_n    = S_SEG_CAP;
			end
			S_SEG_CAP: begin
				cmd.cap_diff = 1'b1;
				state_n      = S_MUL;
			end
			S_MUL: begin
				if (sts.zero_width) begin
					cmd.res_zero = 1'b1;
					state_n      = S_OUT;
				end else begin
					cmd.mul = 1'b1;
					state_n = S_VAL_GO;
				end
			end
			S_VAL_GO: begin
				cmd.div_start = 1'b1;
				state_n       = S_VAL_WAIT;
			end
			S_VAL_WAIT: begin
				if (sts.div_done) begin
					cmd.cap_value = 1'b1;
					state_n       = S_SL_GO;
				end
			end
			S_SL_GO: begin
				if (sts.slope_ovf) begin
					cmd.cap_slope = 1'b1;
					state_n       = S_OUT;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_slope = 1'b1;
					state_n       = S_SL_WAIT;
				end
			end
			S_SL_WAIT: begin
				if (sts.div_done) begin
					cmd.cap_slope = 1'b1;
					state_n       = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

[hw/rtl/piecewise_linear_interpolator_core.sv]
// piecewise_linear_interpolator_core: top level of the interpolation table
// depends on pli_pkg, pli_ctrl, pli_datapath (and pli_div below it)
//
// usage
// - in channel (in_valid/in_ready/in_data): a word with func write loads one
//   breakpoint (entry_index, point_x, point_y) in the cycle it is taken and
//   gives no result; a word with func evaluate carries the query in point_x
// - out channel (out_valid/out_ready/out_data): one result word per evaluate,
//   value, slope, segment index and status, all Q16.16 where signed
// - cfg channel (cfg_valid/cfg_ready/cfg_data): point_count, always ready,
//   to be written only while no evaluate is in flight
// - a write is taken in idle and leaves the input open; an evaluate holds the
//   input until its result is loaded: two table reads, the binary search with
//   a read and a compare state per probe over the single memory read port,
//   then segment fetch and multiply, and two divider passes (value, slope);
//   an outside query or zero width skips them, a slope overflow the second
// - the result sits in an output register; the next word is taken while it
//   waits, and only the load of the following result stalls on out_ready
// - reset returns to idle with no result pending and point_count of two;
//   table entries hold nothing defined until written
`timescale 1ns / 1ps

module piecewise_linear_interpolator_core #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  pli_pkg::pli_in_t                 in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output pli_pkg::pli_out_t                out_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pli_pkg::COUNT_WIDTH-1:0]  cfg_data
);

	// controller to datapath command and status bundles
	pli_pkg::pli_cmd_t cmd;
	pli_pkg::pli_sts_t sts;

	// the count register takes a write in any cycle
	assign cfg_ready = 1'b1;

	// sequencer: one evaluate word in flight at a time
	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (in_data.func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// breakpoint memories, search, multiply, divide and result register
	pli_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

`ifndef SYNTHESIS
	// failing results carry zero value and slope
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != pli_pkg::STATUS_OK |->
		out_data.interp_value == '0 && out_data.interp_slope == '0)
		else $error("non-ok result with non-zero value or slope");

	// a query outside the table reports segment zero
	a_outside_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == pli_pkg::STATUS_OUTSIDE |->
		out_data.segment_index == '0)
		else $error("outside query with non-zero segment index");

	// an accepted evaluate keeps the input closed in the next cycle
	a_eval_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.func == pli_pkg::FUNC_EVAL |=> !in_ready)
		else $error("input still open after evaluate word");

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !out_valid || out_ready)
		else $error("result register overwritten while stalled");
`endif

endmodule
